/* hw/rtl/mmsq_pkg.sv */
package mmsq_pkg;

   // Sizes
   localparam int MAX_DIMS   = 64;
   localparam int DIM_W      = $clog2(MAX_DIMS);
   localparam int SAMPLE_W   = 32;
   localparam int CODE_W     = 8;
   localparam int BITS_W     = 4;
   localparam int ACT_W      = 2;
   localparam int SPAN_W     = SAMPLE_W;
   // 2*diff*levels + span fits here
   localparam int NUM_W      = SPAN_W + CODE_W + 2;
   localparam int STEP_W     = $clog2(CODE_W);

   // CSR port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_QUANT_BITS_IDX = '0;
   localparam logic [BITS_W-1:0]     QUANT_BITS_RESET   = BITS_W'(CODE_W);

   // Actions
   localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_OBSERVE  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUANTIZE = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   typedef struct packed {
      logic [ACT_W-1:0]           action;
      logic [DIM_W-1:0]           dim_index;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]          code;
      logic signed [SAMPLE_W-1:0] range_low;
      logic signed [SAMPLE_W-1:0] range_high;
      logic                       range_empty;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic update;
      logic prep;
      logic mul;
      logic div_step;
      logic load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_div;
   } status_type;

   // Number of levels (2**bits - 1) for a bits setting, with bits clamped to 1..CODE_W
   function automatic logic [CODE_W-1:0] levels_of(input logic [BITS_W-1:0] bits);
      logic [BITS_W-1:0] b;
      logic [CODE_W:0]   full;
      b = bits;
      if (b == '0) begin
         b = BITS_W'(1);
      end else if (b > BITS_W'(CODE_W)) begin
         b = BITS_W'(CODE_W);
      end
      full = ((CODE_W+1)'(1) << b) - (CODE_W+1)'(1);
      return full[CODE_W-1:0];
   endfunction

endpackage

/* hw/rtl/min_max_scalar_quantizer_core.sv */
// Sequence: an accepted item passes the LOAD and PREP states; a quantize beat that
// needs division then passes MUL and the DIV steps. Every beat ends in FIN, which
// loads the output register once the output slot is free. One item at a time.
// Division uses an 8-step restoring divider (one quotient bit per cycle).
// Reset (synchronous, active high): all ranges empty, quant_bits = 8, no result.
module min_max_scalar_quantizer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  mmsq_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output mmsq_pkg::rsp_type                     rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [mmsq_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [mmsq_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [mmsq_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);
   import mmsq_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic [BITS_W-1:0] quant_bits_ff, quant_bits_in;
   logic              csr_hit;

   // Config register
   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == CSR_QUANT_BITS_IDX);
   assign prdata  = csr_hit ? CSR_DATA_W'(quant_bits_ff) : '0;

   always_comb begin
      quant_bits_in = quant_bits_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         quant_bits_in = pwdata[BITS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quant_bits_ff <= QUANT_BITS_RESET;
      end else begin
         quant_bits_ff <= quant_bits_in;
      end
   end

   mmsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mmsq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .quant_bits (quant_bits_ff),
      .status     (status),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // One item in flight: busy right after an accepted beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a beat while busy");

   // Empty dimension reports an all-zero result
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.range_empty |->
         rsp_data.code == '0 && rsp_data.range_low == '0 && rsp_data.range_high == '0)
      else $error("empty result carries data");

   // Effective max lies above min unless saturated
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.range_empty |->
         (rsp_data.range_high > rsp_data.range_low) ||
         (rsp_data.range_low == SAMPLE_MAX && rsp_data.range_high == SAMPLE_MAX))
      else $error("range_high not above range_low");

   // Code never exceeds the level count
   a_code_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.code <= levels_of(quant_bits_ff))
      else $error("code above level count");
`endif

endmodule

/* hw/rtl/mmsq_ctrl.sv */
module mmsq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mmsq_pkg::status_type   status,
   output mmsq_pkg::cmd_type      cmd
);
   import mmsq_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CODE_W - 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.update = 1'b1;
            state_in   = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.need_div ? ST_MUL : ST_FIN;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // wait for a free output slot
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/mmsq_dpath.sv */
module mmsq_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mmsq_pkg::req_type                    req_data,
   input  mmsq_pkg::cmd_type                    cmd,
   input  logic [mmsq_pkg::BITS_W-1:0]          quant_bits,
   output mmsq_pkg::status_type                 status,
   output mmsq_pkg::rsp_type                    rsp_data
);
   import mmsq_pkg::*;

   // Range memories, registered read
   logic signed [SAMPLE_W-1:0] min_mem [MAX_DIMS];
   logic signed [SAMPLE_W-1:0] max_mem [MAX_DIMS];
   logic signed [SAMPLE_W-1:0] rd_min_ff, rd_max_ff;

   logic [MAX_DIMS-1:0]        seen_flags_ff;

   // Item registers
   logic [ACT_W-1:0]           act_ff;
   logic [DIM_W-1:0]           dim_ff;
   logic signed [SAMPLE_W-1:0] x_ff;

   logic signed [SAMPLE_W-1:0] mn_ff, mx_ff, hi_ff;
   logic                       seen_ff;
   logic [SPAN_W-1:0]          span_ff, diff_ff;
   logic [CODE_W-1:0]          levels_ff, code_ff;
   logic [NUM_W-1:0]           num_ff, den_ff;
   rsp_type                    rsp_ff;

   // Observe update
   logic                       seen_old, is_obs, wr_en, seen_in;
   logic signed [SAMPLE_W-1:0] new_min, new_max, mn_in, mx_in;

   always_comb begin
      seen_old = seen_flags_ff[dim_ff];
      is_obs   = (act_ff == ACT_OBSERVE);
      new_min  = (!seen_old || (x_ff < rd_min_ff)) ? x_ff : rd_min_ff;
      new_max  = (!seen_old || (x_ff > rd_max_ff)) ? x_ff : rd_max_ff;
      wr_en    = cmd.update && is_obs;
      mn_in    = is_obs ? new_min : rd_min_ff;
      mx_in    = is_obs ? new_max : rd_max_ff;
      seen_in  = (act_ff == ACT_CLEAR) ? 1'b0 : (is_obs ? 1'b1 : seen_old);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_min_ff <= min_mem[req_data.dim_index];
         rd_max_ff <= max_mem[req_data.dim_index];
      end
      if (wr_en) begin
         min_mem[dim_ff] <= new_min;
         max_mem[dim_ff] <= new_max;
      end
   end

   // Seen flags
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_flags_ff <= '0;
      end else if (cmd.update) begin
         if (act_ff == ACT_CLEAR) begin
            seen_flags_ff <= '0;
         end else if (is_obs) begin
            seen_flags_ff[dim_ff] <= 1'b1;
         end
      end
   end

   // Span, effective max, offset and trivial codes
   logic signed [SAMPLE_W:0]   raw_span, diff_wide;
   logic                       span_pos, diff_pos, diff_ge, is_q;
   logic [SPAN_W-1:0]          span_c;
   logic signed [SAMPLE_W-1:0] hi_c;
   logic [CODE_W-1:0]          levels_c, code_c;

   always_comb begin
      raw_span  = {mx_ff[SAMPLE_W-1], mx_ff} - {mn_ff[SAMPLE_W-1], mn_ff};
      span_pos  = (raw_span > 0);
      span_c    = span_pos ? raw_span[SPAN_W-1:0] : SPAN_W'(1);
      if (span_pos) begin
         hi_c = mx_ff;
      end else if (mn_ff == SAMPLE_MAX) begin
         hi_c = mn_ff;
      end else begin
         hi_c = mn_ff + SAMPLE_W'(1);
      end
      diff_wide = {x_ff[SAMPLE_W-1], x_ff} - {mn_ff[SAMPLE_W-1], mn_ff};
      diff_pos  = (diff_wide > 0);
      diff_ge   = diff_pos && (diff_wide[SPAN_W-1:0] >= span_c);
      is_q      = (act_ff == ACT_QUANTIZE);
      levels_c  = levels_of(quant_bits);
      code_c    = (is_q && seen_ff && diff_ge) ? levels_c : '0;
      status.need_div = is_q && seen_ff && diff_pos && !diff_ge;
   end

   // Multiply stage and restoring divider
   logic [SPAN_W+CODE_W-1:0] prod;
   assign prod = diff_ff * levels_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_data.action;
         dim_ff <= req_data.dim_index;
         x_ff   <= req_data.sample;
      end
      if (cmd.update) begin
         mn_ff   <= mn_in;
         mx_ff   <= mx_in;
         seen_ff <= seen_in;
      end
      if (cmd.prep) begin
         span_ff   <= span_c;
         hi_ff     <= hi_c;
         diff_ff   <= diff_wide[SPAN_W-1:0];
         levels_ff <= levels_c;
         code_ff   <= code_c;
      end else if (cmd.div_step) begin
         code_ff <= {code_ff[CODE_W-2:0], (num_ff >= den_ff)};
      end
      if (cmd.mul) begin
         num_ff <= NUM_W'({prod, 1'b0}) + NUM_W'(span_ff);
         den_ff <= NUM_W'(span_ff) << CODE_W;
      end else if (cmd.div_step) begin
         if (num_ff >= den_ff) begin
            num_ff <= num_ff - den_ff;
         end
         den_ff <= den_ff >> 1;
      end
      // Output register
      if (cmd.load_out) begin
         rsp_ff.code        <= code_ff;
         rsp_ff.range_low   <= seen_ff ? mn_ff : '0;
         rsp_ff.range_high  <= seen_ff ? hi_ff : '0;
         rsp_ff.range_empty <= !seen_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* test/tb_min_max_scalar_quantizer_core.sv */
`timescale 1ns / 1ps

module tb_min_max_scalar_quantizer_core;
   import mmsq_pkg::*;

   localparam logic [ACT_W-1:0]      ACT_UNUSED     = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] QUANT_BITS_ADDR = {CSR_QUANT_BITS_IDX, 2'b00};
   localparam int                    ITEMS_PER_PHASE = 250;
   localparam int                    NUM_PHASES      = 8;
   localparam int                    HOLD_CYCLES     = 300;
   localparam int                    HOLD_AFTER      = 600;
   localparam int                    CYCLE_LIMIT     = 600000;

   // Tracks per-dimension ranges and the code width, predicts each result beat
   class minmax_code_tracker;
      logic signed [SAMPLE_W-1:0] range_min_store[MAX_DIMS];
      logic signed [SAMPLE_W-1:0] range_max_store[MAX_DIMS];
      bit                         dim_seen[MAX_DIMS];
      logic [BITS_W-1:0]          code_bits;
      rsp_type                    range_code_queue[$];
      int errors;
      int accepted;
      int checked;
      int n_observe, n_quantize, n_clear, n_unused, n_empty, n_full_scale;

      function new();
         foreach (dim_seen[i]) dim_seen[i] = 1'b0;
         code_bits = QUANT_BITS_RESET;
         errors = 0;
         accepted = 0;
         checked = 0;
         n_observe = 0;
         n_quantize = 0;
         n_clear = 0;
         n_unused = 0;
         n_empty = 0;
         n_full_scale = 0;
      endfunction

      function void set_code_bits(logic [BITS_W-1:0] b);
         code_bits = b;
      endfunction

      // Update the ranges for one accepted beat and queue its expected result
      function void accept_sample_beat(req_type r);
         rsp_type want;
         longint  lo, span, top, diff, num;
         int      bits, levels;
         want.code        = '0;
         want.range_low   = '0;
         want.range_high  = '0;
         want.range_empty = 1'b1;
         accepted++;
         case (r.action)
            ACT_CLEAR:    n_clear++;
            ACT_OBSERVE:  n_observe++;
            ACT_QUANTIZE: n_quantize++;
            default:      n_unused++;
         endcase
         if (r.action == ACT_CLEAR) begin
            foreach (dim_seen[i]) dim_seen[i] = 1'b0;
         end else begin
            if (r.action == ACT_OBSERVE) begin
               if (!dim_seen[r.dim_index]) begin
                  range_min_store[r.dim_index] = r.sample;
                  range_max_store[r.dim_index] = r.sample;
                  dim_seen[r.dim_index] = 1'b1;
               end else begin
                  if (r.sample < range_min_store[r.dim_index])
                     range_min_store[r.dim_index] = r.sample;
                  if (r.sample > range_max_store[r.dim_index])
                     range_max_store[r.dim_index] = r.sample;
               end
            end
            if (dim_seen[r.dim_index]) begin
               lo   = longint'(range_min_store[r.dim_index]);
               span = longint'(range_max_store[r.dim_index]) - lo;
               // spans under one LSB are widened; high end saturates
               if (span < 1) span = 1;
               top = lo + span;
               if (top > 64'sd2147483647) top = 64'sd2147483647;
               if (r.action == ACT_QUANTIZE) begin
                  bits = int'(code_bits);
                  if (bits < 1) bits = 1;
                  if (bits > CODE_W) bits = CODE_W;
                  levels = (1 << bits) - 1;
                  diff = longint'(r.sample) - lo;
                  if (diff <= 0) begin
                     want.code = '0;
                  end else if (diff >= span) begin
                     want.code = CODE_W'(levels);
                  end else begin
                     // round half up: (2*diff*levels + span) / (2*span)
                     num = (diff * levels * 2 + span) / (span * 2);
                     if (num > levels) num = levels;
                     want.code = CODE_W'(num);
                  end
                  if (int'(want.code) == levels) n_full_scale++;
               end
               want.range_low   = SAMPLE_W'(lo);
               want.range_high  = SAMPLE_W'(top);
               want.range_empty = 1'b0;
            end
         end
         if (want.range_empty) n_empty++;
         range_code_queue.push_back(want);
      endfunction

      task report_mismatch(string what, logic [SAMPLE_W-1:0] got, logic [SAMPLE_W-1:0] want);
         errors++;
         $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
      endtask

      task check_result_beat(rsp_type got);
         rsp_type want;
         checked++;
         if (range_code_queue.size() == 0) begin
            report_mismatch("result beat with nothing outstanding", got.range_low, '0);
            return;
         end
         want = range_code_queue.pop_front();
         if (got.code !== want.code)
            report_mismatch("code", SAMPLE_W'(got.code), SAMPLE_W'(want.code));
         if (got.range_low !== want.range_low)
            report_mismatch("range_low", got.range_low, want.range_low);
         if (got.range_high !== want.range_high)
            report_mismatch("range_high", got.range_high, want.range_high);
         if (got.range_empty !== want.range_empty)
            report_mismatch("range_empty", SAMPLE_W'(got.range_empty),
                            SAMPLE_W'(want.range_empty));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   minmax_code_tracker tracker = new();
   bit quiet = 1'b0;
   bit hold_done = 1'b0;
   int cycle_count = 0;
   int held_cycles = 0;

   min_max_scalar_quantizer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result_beat(rsp_data);
   end

   // Receiver: random stall bursts, one long hold-off, none when quiet
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && tracker.accepted >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               held_cycles++;
            end
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // Drive one sample beat, with an occasional idle burst ahead of it
   task automatic send(input logic [ACT_W-1:0] act, input logic [DIM_W-1:0] dim,
                       input logic signed [SAMPLE_W-1:0] smp);
      req_type r;
      r.action    = act;
      r.dim_index = dim;
      r.sample    = smp;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      tracker.accept_sample_beat(r);
   endtask

   // Stop offering and let every outstanding result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.range_code_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_code_bits(input logic [BITS_W-1:0] b);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= QUANT_BITS_ADDR;
      pwdata  <= {(CSR_DATA_W-BITS_W)'($urandom), b};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tracker.set_code_bits(b);
   endtask

   task automatic check_code_bits(input logic [BITS_W-1:0] b);
      logic [CSR_DATA_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= QUANT_BITS_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== CSR_DATA_W'(b))
         tracker.report_mismatch("quant_bits readback", got, CSR_DATA_W'(b));
   endtask

   // Random value within spread of center, saturated to the sample range
   function automatic logic signed [SAMPLE_W-1:0] pick_near(longint center, longint spread);
      longint v;
      v = center + (longint'($urandom) % (2 * spread + 1)) - spread;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return SAMPLE_W'(v);
   endfunction

   // Observe a handful of dimensions, then quantize against them, with some noise
   task automatic run_vector_set();
      logic [DIM_W-1:0] dims[8];
      longint           ctr[8];
      longint           spr[8];
      int               n_dims, n_obs, n_q, i, k;
      logic signed [SAMPLE_W-1:0] s;
      n_dims = $urandom_range(1, 8);
      for (i = 0; i < n_dims; i++) begin
         dims[i] = DIM_W'($urandom);
         case ($urandom_range(0, 3))
            0:       ctr[i] = 0;
            1:       ctr[i] = longint'(int'($urandom));
            2:       ctr[i] = 64'sd2147483647 - int'($urandom_range(0, 64));
            default: ctr[i] = -64'sd2147483648 + int'($urandom_range(0, 64));
         endcase
         case ($urandom_range(0, 4))
            0:       spr[i] = 0;
            1:       spr[i] = $urandom_range(1, 4);
            2:       spr[i] = $urandom_range(1, 256);
            3:       spr[i] = $urandom_range(1, 1 << 20);
            default: spr[i] = longint'($urandom) >> 1;
         endcase
      end
      if ($urandom_range(0, 2) == 0)
         send(ACT_CLEAR, DIM_W'($urandom), SAMPLE_W'($urandom));
      n_obs = $urandom_range(1, 12);
      for (i = 0; i < n_obs; i++) begin
         k = $urandom_range(0, n_dims - 1);
         send(ACT_OBSERVE, dims[k], pick_near(ctr[k], spr[k]));
      end
      n_q = $urandom_range(1, 16);
      for (i = 0; i < n_q; i++) begin
         k = $urandom_range(0, n_dims - 1);
         if ($urandom_range(0, 9) == 0) begin
            send(ACT_W'($urandom_range(0, 3)), DIM_W'($urandom), SAMPLE_W'($urandom));
         end else begin
            case ($urandom_range(0, 5))
               0:       s = pick_near(ctr[k], spr[k] * 2 + 2);
               1:       s = SAMPLE_W'($urandom);
               default: s = pick_near(ctr[k], spr[k]);
            endcase
            send(ACT_QUANTIZE, dims[k], s);
         end
      end
   endtask

   initial begin
      logic [BITS_W-1:0] bits_plan[NUM_PHASES];
      int p;
      bits_plan[0] = '0;
      bits_plan[1] = 4'd15;
      bits_plan[2] = 4'd1;
      bits_plan[3] = 4'd8;
      for (p = 4; p < NUM_PHASES; p++) bits_plan[p] = BITS_W'($urandom_range(0, 15));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_code_bits(QUANT_BITS_RESET);

      // Directed: empty dimension, zero span, saturated top, full span
      send(ACT_QUANTIZE, 6'd0, 32'sh0000_0000);
      send(ACT_OBSERVE,  6'd0, 32'sh0000_0000);
      send(ACT_QUANTIZE, 6'd0, 32'sh0000_0000);
      send(ACT_QUANTIZE, 6'd0, 32'sh0000_0001);
      send(ACT_OBSERVE,  6'd63, SAMPLE_MAX);
      send(ACT_QUANTIZE, 6'd63, SAMPLE_MAX);
      send(ACT_QUANTIZE, 6'd63, 32'sh8000_0000);
      send(ACT_OBSERVE,  6'd1, 32'sh8000_0000);
      send(ACT_OBSERVE,  6'd1, SAMPLE_MAX);
      send(ACT_QUANTIZE, 6'd1, 32'sh8000_0000);
      send(ACT_QUANTIZE, 6'd1, SAMPLE_MAX);
      send(ACT_QUANTIZE, 6'd1, 32'sh0000_0000);
      send(ACT_QUANTIZE, 6'd1, 32'shFFFF_FFFF);
      // unused action on a populated and on an empty dimension
      send(ACT_UNUSED,   6'd1, 32'sh1234_5678);
      send(ACT_UNUSED,   6'd5, 32'shA5A5_A5A5);
      // below, above, exact half step and near midpoint
      send(ACT_OBSERVE,  6'd2, 32'sh0001_0000);
      send(ACT_OBSERVE,  6'd2, 32'sh0003_0000);
      send(ACT_QUANTIZE, 6'd2, 32'sh0000_0000);
      send(ACT_QUANTIZE, 6'd2, 32'sh0004_0000);
      send(ACT_QUANTIZE, 6'd2, 32'sh0002_0000);
      send(ACT_QUANTIZE, 6'd2, 32'sh0002_0101);
      // clear drops every range, then reseed one
      send(ACT_CLEAR,    6'd1, 32'sh7654_3210);
      send(ACT_QUANTIZE, 6'd1, 32'sh0000_0000);
      send(ACT_OBSERVE,  6'd1, 32'sh0000_0005);
      send(ACT_QUANTIZE, 6'd2, 32'sh0002_0000);
      wait_idle();

      // Random phases, one code width each; the last runs without idling
      for (p = 0; p < NUM_PHASES; p++) begin
         quiet = (p == NUM_PHASES - 1);
         write_code_bits(bits_plan[p]);
         check_code_bits(bits_plan[p]);
         while (tracker.accepted < 25 + (p + 1) * ITEMS_PER_PHASE) run_vector_set();
         wait_idle();
      end
      repeat (30) @(posedge clock);

      $display("Ran %0d sample beats (%0d observe, %0d quantize, %0d clear, %0d unused action).",
               tracker.accepted, tracker.n_observe, tracker.n_quantize, tracker.n_clear,
               tracker.n_unused);
      $display("Checked %0d results, %0d empty, %0d full scale; hold-off %0d cycles.",
               tracker.checked, tracker.n_empty, tracker.n_full_scale, held_cycles);
      if (tracker.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
